### rtl/core/integer_text_parser_base_detect_macros.svh
// ----------------------------------------------------------------------------
// integer text parser assertion macros
// shared concurrent assertion forms, clocked on clk_i, off while in reset
// ----------------------------------------------------------------------------
`ifndef INTEGER_TEXT_PARSER_BASE_DETECT_MACROS_SVH
`define INTEGER_TEXT_PARSER_BASE_DETECT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ITP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ITP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// types, character codes and decode helpers of the integer text parser
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int unsigned OffsetWidth = 16;
  localparam int unsigned ValueWidth  = 64;
  localparam int unsigned BaseWidth   = 6;
  localparam int unsigned DigitWidth  = 6;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7a;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5a;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] LetterOffset = 8'd10;

  localparam logic [BaseWidth-1:0] BaseAuto = 6'd0;
  localparam logic [BaseWidth-1:0] Base8    = 6'd8;
  localparam logic [BaseWidth-1:0] Base10   = 6'd10;
  localparam logic [BaseWidth-1:0] Base16   = 6'd16;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       string_start;
  } itp_in_t;

  typedef struct packed {
    logic [ValueWidth-1:0]  parsed_value;
    logic [OffsetWidth-1:0] end_offset;
  } itp_out_t;

  typedef struct packed {
    logic                  valid;
    logic [DigitWidth-1:0] value;
  } itp_digit_t;

  typedef enum logic [3:0] {
    PhDone   = 4'b0001,
    PhLead   = 4'b0010,
    PhDigits = 4'b0100,
    PhHexPfx = 4'b1000
  } itp_phase_e;

  function automatic itp_digit_t digit_decode(logic [7:0] c);
    itp_digit_t r;
    logic [7:0] v;
    r = '0;
    v = '0;
    if (c >= ChZero && c <= ChNine) begin
      v = c - ChZero;
      r.valid = 1'b1;
    end else if (c >= ChLowA && c <= ChLowZ) begin
      v = c - ChLowA + LetterOffset;
      r.valid = 1'b1;
    end else if (c >= ChUpA && c <= ChUpZ) begin
      v = c - ChUpA + LetterOffset;
      r.valid = 1'b1;
    end
    r.value = v[DigitWidth-1:0];
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

endpackage

### rtl/core/integer_text_parser_base_detect.sv
// ----------------------------------------------------------------------------
// integer_text_parser_base_detect
// streaming unsigned integer parser with radix detection, one byte a beat
// ----------------------------------------------------------------------------
// Usage: text bytes enter on the in channel (valid/ready), one byte a beat,
// string_start high on the first byte of each string. A parse ends on the
// first byte that is not a digit of the radix; that byte makes one beat on
// the out channel with the value (mod 2^64) and the count of bytes consumed.
// Bytes after the end and before the next start make no beat.
// The radix register is written over the cfg channel (always ready) and is
// latched at each start byte; write it only while the block is idle.
// Throughput: one byte per cycle unless a held result stalls the input, set
// by the single multiply-add of the 64-bit accumulator by the radix in the
// parse stage. The out beat is registered: a byte that ends a parse passes
// the input register, then the parse stage into the result register, before
// out_valid_o rises.
// Reset clears the phase to waiting for a start, the radix register to auto
// detect and both valid flags. A stalled receiver holds the result register;
// the input register then fills and in_ready_o drops until the beat is taken.
// ----------------------------------------------------------------------------
module integer_text_parser_base_detect
  import itp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [BaseWidth-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  itp_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output itp_out_t             out_data_o
);

  localparam logic [OffsetWidth-1:0] CntMax = '1;

  logic [BaseWidth-1:0]   cfg_base_q;
  logic                   in_valid_q;
  itp_in_t                in_q;
  itp_phase_e             phase_q, phase_d;
  logic [BaseWidth-1:0]   base_q, base_d;
  logic [ValueWidth-1:0]  acc_q, acc_d;
  logic [OffsetWidth-1:0] cnt_q, cnt_d;
  logic                   zl_q, zl_d;
  logic                   out_valid_q, out_valid_d;
  itp_out_t               out_q, res_d;
  logic                   emit;
  logic                   proc_fire;

  itp_phase_e             cur_phase;
  logic [BaseWidth-1:0]   cur_base;
  logic [BaseWidth-1:0]   lead_base;
  logic [ValueWidth-1:0]  cur_acc;
  logic [OffsetWidth-1:0] cur_cnt, cnt_inc, cnt_inc2;
  logic                   cur_zl;
  itp_digit_t             dig;
  logic [ValueWidth-1:0]  mac;

  assign cfg_ready_o = 1'b1;
  assign proc_fire   = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || proc_fire;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign dig       = digit_decode(in_q.char_byte);
  assign cur_phase = in_q.string_start ? PhLead : phase_q;
  assign cur_base  = in_q.string_start ? cfg_base_q : base_q;
  assign cur_acc   = in_q.string_start ? '0 : acc_q;
  assign cur_cnt   = in_q.string_start ? '0 : cnt_q;
  assign cur_zl    = in_q.string_start ? 1'b0 : zl_q;
  assign lead_base = (cur_base == BaseAuto) ? Base10 : cur_base;
  assign cnt_inc   = (cur_cnt == CntMax) ? CntMax : cur_cnt + 1'b1;
  assign cnt_inc2  = (cur_cnt >= CntMax - 1'b1) ? CntMax : cur_cnt + 2'd2;
  assign mac       = acc_q * {{(ValueWidth-BaseWidth){1'b0}}, base_q}
                   + {{(ValueWidth-DigitWidth){1'b0}}, dig.value};

  always_comb begin
    phase_d = cur_phase;
    base_d  = cur_base;
    acc_d   = cur_acc;
    cnt_d   = cur_cnt;
    zl_d    = cur_zl;
    emit    = 1'b0;
    res_d   = '0;
    unique case (cur_phase)
      PhLead: begin
        if (is_space(in_q.char_byte)) begin
          cnt_d = cnt_inc;
        end else if (in_q.char_byte == ChZero &&
                     (cur_base == BaseAuto || cur_base == Base16)) begin
          if (cur_base == BaseAuto) begin
            base_d = Base8;
          end
          zl_d    = 1'b1;
          acc_d   = '0;
          cnt_d   = cnt_inc;
          phase_d = PhDigits;
        end else begin
          base_d = lead_base;
          if (dig.valid && dig.value < lead_base) begin
            acc_d   = {{(ValueWidth-DigitWidth){1'b0}}, dig.value};
            cnt_d   = cnt_inc;
            phase_d = PhDigits;
          end else begin
            emit    = 1'b1;
            phase_d = PhDone;
            zl_d    = 1'b0;
          end
        end
      end
      PhDigits: begin
        zl_d = 1'b0;
        if (cur_zl && (in_q.char_byte == ChLowX || in_q.char_byte == ChUpX)) begin
          base_d  = Base16;
          phase_d = PhHexPfx;
        end else if (dig.valid && dig.value < cur_base) begin
          acc_d = mac;
          cnt_d = cnt_inc;
        end else begin
          emit             = 1'b1;
          res_d.parsed_value = cur_acc;
          res_d.end_offset   = cur_cnt;
          phase_d          = PhDone;
        end
      end
      PhHexPfx: begin
        if (dig.valid && dig.value < Base16) begin
          acc_d   = {{(ValueWidth-DigitWidth){1'b0}}, dig.value};
          cnt_d   = cnt_inc2;
          phase_d = PhDigits;
        end else begin
          emit           = 1'b1;
          res_d.end_offset = cur_cnt;
          phase_d        = PhDone;
          zl_d           = 1'b0;
        end
      end
      PhDone: begin
        phase_d = PhDone;
      end
      default: begin
        phase_d = PhDone;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || (proc_fire && emit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_base_q  <= BaseAuto;
      in_valid_q  <= 1'b0;
      phase_q     <= PhDone;
      base_q      <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      zl_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cfg_base_q <= cfg_data_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (proc_fire) begin
        phase_q <= phase_d;
        base_q  <= base_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
        zl_q    <= zl_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (proc_fire && emit) begin
      out_q <= res_d;
    end
  end

endmodule

### rtl/core/itp_port_checker.sv
// ----------------------------------------------------------------------------
// itp_port_checker
// port level checks of the integer text parser, bound to the top level
// ----------------------------------------------------------------------------
`include "integer_text_parser_base_detect_macros.svh"

module itp_port_checker
  import itp_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input logic [BaseWidth-1:0] cfg_data_i,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input itp_in_t              in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input itp_out_t             out_data_o
);

  // result beat holds until taken
  `ITP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "out beat dropped or changed while stalled")

  // config channel never stalls
  `ITP_ASSERT_IMPL(a_cfg_ready, cfg_valid_i, cfg_ready_o, "cfg channel not ready")

  // input stalls only behind a held result
  `ITP_ASSERT_IMPL(a_in_stall, !in_ready_o, out_valid_o && !out_ready_i, "input stalled without a held result")

endmodule

bind integer_text_parser_base_detect itp_port_checker u_itp_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_data_i  (cfg_data_i),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
